@@ rtl/ssd_pkg.sv @@
// Shared constants and types of the segment-to-segment distance pipeline.
package ssd_pkg;

	// Default signed coordinate width of the input points.
	localparam int COORD_WIDTH_DEF = 24;

	// Fraction bits of the clamped segment parameters s and t.
	localparam int PARAM_BITS = 24;

	localparam int THRESH_WIDTH = 25;
	localparam int DIST_WIDTH   = 25;

	localparam logic [THRESH_WIDTH-1:0] THRESH_RESET = THRESH_WIDTH'(1678);
	localparam logic [DIST_WIDTH-1:0]   DIST_MAX     = {DIST_WIDTH{1'b1}};

	// A parameter of exactly 1.0.
	localparam logic [PARAM_BITS:0] PARAM_ONE = {1'b1, {PARAM_BITS{1'b0}}};

	// Multiplier limb width; partial products are (MUL_LIMB+1) bits square.
	localparam int MUL_LIMB = 30;
	localparam int MUL_LAT  = 2;

	// Divider depth: one setup stage and one stage per quotient bit.
	localparam int DIV_LAT = PARAM_BITS + 1;

	// Which clamping branch an item takes.
	typedef enum logic [2:0] {
		PC_BOTH_POINTS,
		PC_FIRST_POINT,
		PC_SECOND_POINT,
		PC_T_LOW,
		PC_T_HIGH,
		PC_T_MID
	} pair_case_t;

endpackage

@@ rtl/ssd_ifs.sv @@
// Channel interfaces of the segment-to-segment distance block.
interface ssd_seg_if #(
	parameter int CW = ssd_pkg::COORD_WIDTH_DEF
);
	logic valid;
	logic ready;
	logic signed [CW-1:0] first_start_x;
	logic signed [CW-1:0] first_start_y;
	logic signed [CW-1:0] first_start_z;
	logic signed [CW-1:0] first_end_x;
	logic signed [CW-1:0] first_end_y;
	logic signed [CW-1:0] first_end_z;
	logic signed [CW-1:0] second_start_x;
	logic signed [CW-1:0] second_start_y;
	logic signed [CW-1:0] second_start_z;
	logic signed [CW-1:0] second_end_x;
	logic signed [CW-1:0] second_end_y;
	logic signed [CW-1:0] second_end_z;

	modport source (
		output valid, first_start_x, first_start_y, first_start_z,
		first_end_x, first_end_y, first_end_z,
		second_start_x, second_start_y, second_start_z,
		second_end_x, second_end_y, second_end_z,
		input ready
	);
	modport sink (
		input valid, first_start_x, first_start_y, first_start_z,
		first_end_x, first_end_y, first_end_z,
		second_start_x, second_start_y, second_start_z,
		second_end_x, second_end_y, second_end_z,
		output ready
	);
endinterface

interface ssd_dist_if;
	logic valid;
	logic ready;
	logic [ssd_pkg::DIST_WIDTH-1:0] distance;

	modport source (output valid, distance, input ready);
	modport sink (input valid, distance, output ready);
endinterface

interface ssd_cfg_if;
	logic valid;
	logic ready;
	logic [ssd_pkg::THRESH_WIDTH-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

@@ rtl/ssd_delay.sv @@
// Enabled delay line that carries side values alongside the long units.
module ssd_delay #(
	parameter int W     = 1,
	parameter int DEPTH = 1
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic [W-1:0] din,
	output logic [W-1:0] dout
);
	logic [W-1:0] line_q [DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DEPTH; k++) begin
				line_q[k] <= '0;
			end
		end else if (en) begin
			line_q[0] <= din;
			for (int k = 1; k < DEPTH; k++) begin
				line_q[k] <= line_q[k-1];
			end
		end
	end

	assign dout = line_q[DEPTH-1];
endmodule

@@ rtl/ssd_mul.sv @@
// Two-stage signed multiplier built from registered limb partial products.
module ssd_mul #(
	parameter int AW = 32,
	parameter int BW = 32
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [AW-1:0] a_in,
	input  logic signed [BW-1:0] b_in,
	output logic signed [AW+BW-1:0] prod
);
	import ssd_pkg::*;

	localparam int LW = MUL_LIMB;
	localparam int NA = (AW + LW - 1) / LW;
	localparam int NB = (BW + LW - 1) / LW;

	logic signed [NA*LW-1:0] a_ext;
	logic signed [NB*LW-1:0] b_ext;
	logic signed [LW:0]      a_limb [NA];
	logic signed [LW:0]      b_limb [NB];
	logic signed [2*LW+1:0]  pp_s1 [NA][NB];
	logic signed [AW+BW-1:0] acc;

	assign a_ext = (NA*LW)'(a_in);
	assign b_ext = (NB*LW)'(b_in);

	// Lower limbs are unsigned; the top limb carries the sign.
	always_comb begin
		for (int i = 0; i < NA; i++) begin
			if (i == NA - 1) begin
				a_limb[i] = {a_ext[i*LW+LW-1], a_ext[i*LW +: LW]};
			end else begin
				a_limb[i] = {1'b0, a_ext[i*LW +: LW]};
			end
		end
		for (int j = 0; j < NB; j++) begin
			if (j == NB - 1) begin
				b_limb[j] = {b_ext[j*LW+LW-1], b_ext[j*LW +: LW]};
			end else begin
				b_limb[j] = {1'b0, b_ext[j*LW +: LW]};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NA; i++) begin
				for (int j = 0; j < NB; j++) begin
					pp_s1[i][j] <= a_limb[i] * b_limb[j];
				end
			end
		end
	end

	always_comb begin
		acc = '0;
		for (int i = 0; i < NA; i++) begin
			for (int j = 0; j < NB; j++) begin
				acc = acc + ((AW+BW)'(pp_s1[i][j]) <<< (LW*(i+j)));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod <= acc;
		end
	end
endmodule

@@ rtl/ssd_div.sv @@
// Pipelined restoring divider giving a clamped fraction num/den in [0, 1].
module ssd_div #(
	parameter int NW = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic signed [NW-1:0] num,
	input  logic signed [NW-1:0] den,
	output logic [ssd_pkg::PARAM_BITS:0] quo
);
	import ssd_pkg::*;

	logic [NW-1:0]         rem_s  [PARAM_BITS+1];
	logic [NW-1:0]         den_s  [PARAM_BITS+1];
	logic [PARAM_BITS-1:0] q_s    [PARAM_BITS+1];
	logic                  zero_s [PARAM_BITS+1];
	logic                  one_s  [PARAM_BITS+1];

	// Setup stage: non-positive operands give zero, num at or above den gives one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_s[0] <= 1'b1;
			one_s[0]  <= 1'b0;
		end else if (en) begin
			zero_s[0] <= (den <= 0) || (num <= 0);
			one_s[0]  <= (num >= den);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= num;
			den_s[0] <= den;
			q_s[0]   <= '0;
		end
	end

	for (genvar k = 1; k <= PARAM_BITS; k++) begin : g_step
		logic [NW-1:0] rem2;
		logic          ge;

		assign rem2 = {rem_s[k-1][NW-2:0], 1'b0};
		assign ge   = (rem2 >= den_s[k-1]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				zero_s[k] <= 1'b1;
				one_s[k]  <= 1'b0;
			end else if (en) begin
				zero_s[k] <= zero_s[k-1];
				one_s[k]  <= one_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? (rem2 - den_s[k-1]) : rem2;
				den_s[k] <= den_s[k-1];
				q_s[k]   <= {q_s[k-1][PARAM_BITS-2:0], ge};
			end
		end
	end

	always_comb begin
		if (zero_s[PARAM_BITS]) begin
			quo = '0;
		end else if (one_s[PARAM_BITS]) begin
			quo = PARAM_ONE;
		end else begin
			quo = {1'b0, q_s[PARAM_BITS]};
		end
	end
endmodule

@@ rtl/ssd_sqrt.sv @@
// Pipelined floor square root, one root bit per stage.
module ssd_sqrt #(
	parameter int XW = 32
) (
	input  logic                  clk,
	input  logic                  en,
	input  logic [XW-1:0]         x,
	output logic [(XW+1)/2-1:0]   root
);
	localparam int RW   = (XW + 1) / 2;
	localparam int REMW = RW + 3;

	logic [2*RW-1:0] x_s    [RW];
	logic [REMW-1:0] rem_s  [RW];
	logic [RW-1:0]   root_s [RW];

	for (genvar k = 0; k < RW; k++) begin : g_digit
		logic [2*RW-1:0] x_prev;
		logic [REMW-1:0] rem_prev;
		logic [RW-1:0]   root_prev;
		logic [REMW-1:0] cur;
		logic [REMW-1:0] trial;
		logic            ge;

		if (k == 0) begin : g_first
			assign x_prev    = (2*RW)'(x);
			assign rem_prev  = '0;
			assign root_prev = '0;
		end else begin : g_next
			assign x_prev    = x_s[k-1];
			assign rem_prev  = rem_s[k-1];
			assign root_prev = root_s[k-1];
		end

		assign cur   = {rem_prev[REMW-3:0], x_prev[2*(RW-1-k) +: 2]};
		assign trial = REMW'({root_prev, 2'b01});
		assign ge    = (cur >= trial);

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[k]    <= x_prev;
				rem_s[k]  <= ge ? (cur - trial) : cur;
				root_s[k] <= {root_prev[RW-2:0], ge};
			end
		end
	end

	assign root = root_s[RW-1];
endmodule

@@ rtl/segment_segment_distance.sv @@
// Shortest distance between two 3D segments. Throughput is one transaction per cycle
// while no result is held; the two 24-step dividers in series and the one-bit-per-stage
// square root set the depth, and every stage advances together.
// A held result stalls the whole pipeline, so input ready drops only while a result is held.
// Reset (arst_n low) clears all valid bits and loads the degenerate threshold with 1678.
module segment_segment_distance #(
	parameter int COORD_WIDTH = ssd_pkg::COORD_WIDTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	ssd_seg_if.sink    seg_in,
	ssd_dist_if.source dist_out,
	ssd_cfg_if.sink    cfg
);
	import ssd_pkg::*;

	// Widths: direction differences, dot products, the determinant terms, the
	// refit numerator for t, the clamp numerator for s, parameters, and the
	// closest-point offset with 24 extra fraction bits.
	localparam int DW   = COORD_WIDTH + 1;
	localparam int DOTW = 2*DW + 2;
	localparam int WW   = 2*DOTW + 1;
	localparam int TW   = DOTW + PARAM_BITS + 3;
	localparam int NW3  = DOTW + 1;
	localparam int SW   = PARAM_BITS + 1;
	localparam int CMPW = DW + PARAM_BITS + 2;
	localparam int SQW  = 2*CMPW + 2;
	localparam int RTW  = SQW / 2;
	localparam int XW   = RTW + DIST_WIDTH;

	// Stage numbers at which each group of values sits in registers.
	localparam int ST_DIFF  = 1;
	localparam int ST_DOT   = 2;
	localparam int ST_WPROD = ST_DOT + MUL_LAT;
	localparam int ST_SDIV  = ST_WPROD + 1;
	localparam int ST_SMAIN = ST_SDIV + DIV_LAT;
	localparam int ST_BS    = ST_SMAIN + MUL_LAT;
	localparam int ST_OPS   = ST_BS + 1;
	localparam int ST_QT    = ST_OPS + DIV_LAT;
	localparam int ST_ST    = ST_QT + 1;
	localparam int ST_DP    = ST_ST + 1;
	localparam int ST_COMP  = ST_DP + 1;
	localparam int ST_SQ    = ST_COMP + MUL_LAT;
	localparam int ST_SUM   = ST_SQ + 1;
	localparam int ST_ROOT  = ST_SUM + RTW;
	localparam int ST_OUT   = ST_ROOT + 1;

	// Every stage moves when the output register is free or being emptied.
	logic adv;
	assign adv          = !dist_out.valid || dist_out.ready;
	assign seg_in.ready = adv;

	// The threshold register takes a write in any cycle.
	logic [THRESH_WIDTH-1:0] thresh_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= THRESH_RESET;
		end else if (cfg.valid) begin
			thresh_q <= cfg.data;
		end
	end

	// One valid bit per stage, shifted in step with the data.
	ssd_delay #(.W(1), .DEPTH(ST_OUT)) u_vld (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (adv),
		.din   (seg_in.valid),
		.dout  (dist_out.valid)
	);

	// Stage 1: segment directions d1, d2 and the start offset r = p1 - p2.
	logic signed [DW-1:0] d1_s1 [3];
	logic signed [DW-1:0] d2_s1 [3];
	logic signed [DW-1:0] r_s1  [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			d1_s1[0] <= DW'(seg_in.first_end_x) - DW'(seg_in.first_start_x);
			d1_s1[1] <= DW'(seg_in.first_end_y) - DW'(seg_in.first_start_y);
			d1_s1[2] <= DW'(seg_in.first_end_z) - DW'(seg_in.first_start_z);
			d2_s1[0] <= DW'(seg_in.second_end_x) - DW'(seg_in.second_start_x);
			d2_s1[1] <= DW'(seg_in.second_end_y) - DW'(seg_in.second_start_y);
			d2_s1[2] <= DW'(seg_in.second_end_z) - DW'(seg_in.second_start_z);
			r_s1[0]  <= DW'(seg_in.first_start_x) - DW'(seg_in.second_start_x);
			r_s1[1]  <= DW'(seg_in.first_start_y) - DW'(seg_in.second_start_y);
			r_s1[2]  <= DW'(seg_in.first_start_z) - DW'(seg_in.second_start_z);
		end
	end

	// Stage 2: the five dot products a = d1.d1, b = d1.d2, c = d1.r, e = d2.d2, f = d2.r.
	logic signed [2*DW-1:0] pa [3];
	logic signed [2*DW-1:0] pb [3];
	logic signed [2*DW-1:0] pc [3];
	logic signed [2*DW-1:0] pe [3];
	logic signed [2*DW-1:0] pf [3];
	logic signed [DOTW-1:0] a_s2, b_s2, c_s2, e_s2, f_s2;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			pa[k] = d1_s1[k] * d1_s1[k];
			pb[k] = d1_s1[k] * d2_s1[k];
			pc[k] = d1_s1[k] * r_s1[k];
			pe[k] = d2_s1[k] * d2_s1[k];
			pf[k] = d2_s1[k] * r_s1[k];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s2 <= DOTW'(pa[0]) + DOTW'(pa[1]) + DOTW'(pa[2]);
			b_s2 <= DOTW'(pb[0]) + DOTW'(pb[1]) + DOTW'(pb[2]);
			c_s2 <= DOTW'(pc[0]) + DOTW'(pc[1]) + DOTW'(pc[2]);
			e_s2 <= DOTW'(pe[0]) + DOTW'(pe[1]) + DOTW'(pe[2]);
			f_s2 <= DOTW'(pf[0]) + DOTW'(pf[1]) + DOTW'(pf[2]);
		end
	end

	// A segment whose squared length is at or below the threshold is a point.
	logic adeg, edeg;
	assign adeg = (a_s2 <= $signed(DOTW'(thresh_q)));
	assign edeg = (e_s2 <= $signed(DOTW'(thresh_q)));

	// Stages 3 and 4: the products for s = (b*f - c*e) / (a*e - b*b).
	logic signed [2*DOTW-1:0] bf_v, ce_v, ae_v, bb_v;

	ssd_mul #(.AW(DOTW), .BW(DOTW)) u_mul_bf (
		.clk(clk), .en(adv), .a_in(b_s2), .b_in(f_s2), .prod(bf_v));
	ssd_mul #(.AW(DOTW), .BW(DOTW)) u_mul_ce (
		.clk(clk), .en(adv), .a_in(c_s2), .b_in(e_s2), .prod(ce_v));
	ssd_mul #(.AW(DOTW), .BW(DOTW)) u_mul_ae (
		.clk(clk), .en(adv), .a_in(a_s2), .b_in(e_s2), .prod(ae_v));
	ssd_mul #(.AW(DOTW), .BW(DOTW)) u_mul_bb (
		.clk(clk), .en(adv), .a_in(b_s2), .b_in(b_s2), .prod(bb_v));

	// Stage 5: numerator and determinant of the unclamped s.
	logic signed [WW-1:0] sn_s5, sd_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			sn_s5 <= WW'(bf_v) - WW'(ce_v);
			sd_s5 <= WW'(ae_v) - WW'(bb_v);
		end
	end

	logic [SW-1:0] s_main;

	ssd_div #(.NW(WW)) u_div_s (
		.clk(clk), .arst_n(arst_n), .en(adv),
		.num(sn_s5), .den(sd_s5), .quo(s_main));

	// The dot products and point flags ride along until t is refit.
	logic [DOTW-1:0] b_early;

	ssd_delay #(.W(DOTW), .DEPTH(ST_SMAIN - ST_DOT)) u_dly_b (
		.clk(clk), .arst_n(arst_n), .en(adv), .din(b_s2), .dout(b_early));

	logic [5*DOTW+1:0] dots_dly;
	logic              adeg_d, edeg_d;
	logic signed [DOTW-1:0] a_d, b_d, c_d, e_d, f_d;

	ssd_delay #(.W(5*DOTW + 2), .DEPTH(ST_BS - ST_DOT)) u_dly_dots (
		.clk(clk), .arst_n(arst_n), .en(adv),
		.din({adeg, edeg, a_s2, b_s2, c_s2, e_s2, f_s2}), .dout(dots_dly));

	assign adeg_d = dots_dly[5*DOTW+1];
	assign edeg_d = dots_dly[5*DOTW];
	assign a_d    = $signed(dots_dly[4*DOTW +: DOTW]);
	assign b_d    = $signed(dots_dly[3*DOTW +: DOTW]);
	assign c_d    = $signed(dots_dly[2*DOTW +: DOTW]);
	assign e_d    = $signed(dots_dly[DOTW +: DOTW]);
	assign f_d    = $signed(dots_dly[0 +: DOTW]);

	// Stages 31 and 32: b*s for the refit of t.
	logic signed [DOTW+SW:0] bs_v;

	ssd_mul #(.AW(DOTW), .BW(SW + 1)) u_mul_bs (
		.clk(clk), .en(adv), .a_in($signed(b_early)), .b_in($signed({1'b0, s_main})),
		.prod(bs_v));

	// t = (b*s + f) / e with s in fixed point; the branch taken decides which
	// divisions the next two dividers perform.
	logic signed [TW-1:0]  num_t, den_t;
	logic signed [TW-1:0]  n2_sel, d2_sel;
	logic signed [NW3-1:0] n3_sel;
	pair_case_t            pcase;

	always_comb begin
		num_t = TW'(bs_v) + (TW'(f_d) <<< PARAM_BITS);
		den_t = TW'(e_d) <<< PARAM_BITS;
		if (adeg_d && edeg_d) begin
			pcase = PC_BOTH_POINTS;
		end else if (adeg_d) begin
			pcase = PC_FIRST_POINT;
		end else if (edeg_d) begin
			pcase = PC_SECOND_POINT;
		end else if (num_t < 0) begin
			pcase = PC_T_LOW;
		end else if (den_t < num_t) begin
			pcase = PC_T_HIGH;
		end else begin
			pcase = PC_T_MID;
		end
		// The first segment as a point divides f by e; otherwise t is refit.
		if (adeg_d) begin
			n2_sel = TW'(f_d);
			d2_sel = TW'(e_d);
		end else begin
			n2_sel = num_t;
			d2_sel = den_t;
		end
		// With t at 1 the first segment is refit from b - c; elsewhere from -c.
		if (pcase == PC_T_HIGH) begin
			n3_sel = NW3'(b_d) - NW3'(c_d);
		end else begin
			n3_sel = -NW3'(c_d);
		end
	end

	// Stage 33: divider operands.
	logic signed [TW-1:0]  n2_s33, d2_s33;
	logic signed [NW3-1:0] n3_s33, d3_s33;

	always_ff @(posedge clk) begin
		if (adv) begin
			n2_s33 <= n2_sel;
			d2_s33 <= d2_sel;
			n3_s33 <= n3_sel;
			d3_s33 <= NW3'(a_d);
		end
	end

	logic [SW-1:0] q_t, q_s;

	ssd_div #(.NW(TW)) u_div_t (
		.clk(clk), .arst_n(arst_n), .en(adv),
		.num(n2_s33), .den(d2_s33), .quo(q_t));
	ssd_div #(.NW(NW3)) u_div_refit (
		.clk(clk), .arst_n(arst_n), .en(adv),
		.num(n3_s33), .den(d3_s33), .quo(q_s));

	logic [SW-1:0] s_main_d;
	logic [2:0]    pcase_bits;
	pair_case_t    pcase_d;

	ssd_delay #(.W(SW), .DEPTH(ST_QT - ST_SMAIN)) u_dly_smain (
		.clk(clk), .arst_n(arst_n), .en(adv), .din(s_main), .dout(s_main_d));
	ssd_delay #(.W(3), .DEPTH(ST_QT - ST_BS)) u_dly_case (
		.clk(clk), .arst_n(arst_n), .en(adv), .din(pcase), .dout(pcase_bits));

	assign pcase_d = pair_case_t'(pcase_bits);

	// Stage 59: final clamped parameters.
	logic [SW-1:0] s_sel, t_sel;
	logic [SW-1:0] s_s59, t_s59;

	always_comb begin
		case (pcase_d)
			PC_BOTH_POINTS: begin
				s_sel = '0;
				t_sel = '0;
			end
			PC_FIRST_POINT: begin
				s_sel = '0;
				t_sel = q_t;
			end
			PC_SECOND_POINT, PC_T_LOW: begin
				s_sel = q_s;
				t_sel = '0;
			end
			PC_T_HIGH: begin
				s_sel = q_s;
				t_sel = PARAM_ONE;
			end
			PC_T_MID: begin
				s_sel = s_main_d;
				t_sel = q_t;
			end
			default: begin
				s_sel = '0;
				t_sel = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			s_s59 <= s_sel;
			t_s59 <= t_sel;
		end
	end

	// Directions wait here for s and t; the offset waits one stage longer.
	logic [6*DW-1:0]      dirs_dly;
	logic [3*DW-1:0]      offs_dly;
	logic signed [DW-1:0] d1_d [3];
	logic signed [DW-1:0] d2_d [3];
	logic signed [DW-1:0] r_d  [3];

	ssd_delay #(.W(6*DW), .DEPTH(ST_ST - ST_DIFF)) u_dly_dirs (
		.clk(clk), .arst_n(arst_n), .en(adv),
		.din({d1_s1[0], d1_s1[1], d1_s1[2], d2_s1[0], d2_s1[1], d2_s1[2]}),
		.dout(dirs_dly));
	ssd_delay #(.W(3*DW), .DEPTH(ST_DP - ST_DIFF)) u_dly_offs (
		.clk(clk), .arst_n(arst_n), .en(adv),
		.din({r_s1[0], r_s1[1], r_s1[2]}), .dout(offs_dly));

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			d1_d[k] = $signed(dirs_dly[(5-k)*DW +: DW]);
			d2_d[k] = $signed(dirs_dly[(2-k)*DW +: DW]);
			r_d[k]  = $signed(offs_dly[(2-k)*DW +: DW]);
		end
	end

	// Stage 60: d1*s and d2*t per axis.
	logic signed [CMPW-1:0] p1_s60 [3];
	logic signed [CMPW-1:0] p2_s60 [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				p1_s60[k] <= d1_d[k] * $signed({1'b0, s_s59});
				p2_s60[k] <= d2_d[k] * $signed({1'b0, t_s59});
			end
		end
	end

	// Stage 61: offset between the two closest points, exact in fixed point.
	logic signed [CMPW-1:0] comp_s61 [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				comp_s61[k] <= (CMPW'(r_d[k]) <<< PARAM_BITS) + p1_s60[k] - p2_s60[k];
			end
		end
	end

	// Stages 62 and 63: squares of the three components.
	logic signed [2*CMPW-1:0] sq_v [3];

	for (genvar k = 0; k < 3; k++) begin : g_sq
		ssd_mul #(.AW(CMPW), .BW(CMPW)) u_mul_sq (
			.clk(clk), .en(adv), .a_in(comp_s61[k]), .b_in(comp_s61[k]), .prod(sq_v[k]));
	end

	// Stage 64: squared distance, never negative.
	logic signed [SQW-1:0] sum_s64;

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s64 <= SQW'(sq_v[0]) + SQW'(sq_v[1]) + SQW'(sq_v[2]);
		end
	end

	logic [RTW-1:0] root_v;

	ssd_sqrt #(.XW(SQW - 1)) u_sqrt (
		.clk(clk), .en(adv), .x(sum_s64[SQW-2:0]), .root(root_v));

	// Output register: drop the parameter fraction bits and saturate.
	logic [XW-1:0]         root_sh;
	logic [DIST_WIDTH-1:0] dist_q;

	assign root_sh = XW'(root_v) >> PARAM_BITS;

	always_ff @(posedge clk) begin
		if (adv) begin
			if (root_sh > XW'(DIST_MAX)) begin
				dist_q <= DIST_MAX;
			end else begin
				dist_q <= root_sh[DIST_WIDTH-1:0];
			end
		end
	end

	assign dist_out.distance = dist_q;

`ifndef SYNTHESIS
	// A write lands in the threshold register on the next edge.
	assert property (@(posedge clk) disable iff (!arst_n)
		cfg.valid |=> (thresh_q == $past(cfg.data)))
		else $error("threshold register missed a configuration write");

	// A held result must stop the input side in the same cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(dist_out.valid && !dist_out.ready) |-> !seg_in.ready)
		else $error("input accepted while the result register is blocked");

	// While the pipeline is stalled, a waiting result keeps its valid bit.
	assert property (@(posedge clk) disable iff (!arst_n)
		(dist_out.valid && !dist_out.ready) |=> dist_out.valid)
		else $error("pending result dropped during a stall");
`endif
endmodule

@@ dv/testbench.sv @@
// Self-checking testbench of the segment-to-segment distance pipeline.
`timescale 1ns / 100ps

module testbench;
	import ssd_pkg::*;

	localparam int CW = 24;
	localparam int ITEMS_PER_PHASE = 110;
	localparam int DRAIN_CYCLES = 200;

	// Exact signed intermediates; 128 bits hold every product at this coordinate width.
	typedef logic signed [127:0] wide_t;

	// One segment pair in port order: first start xyz, first end xyz,
	// second start xyz, second end xyz.
	typedef struct {
		logic signed [CW-1:0] c [12];
	} seg_pair_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	ssd_seg_if #(.CW(CW)) seg_if ();
	ssd_dist_if dist_if ();
	ssd_cfg_if cfg_if ();

	segment_segment_distance #(.COORD_WIDTH(CW)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.seg_in   (seg_if.sink),
		.dist_out (dist_if.source),
		.cfg      (cfg_if.sink)
	);

	always #5 clk = ~clk;

	seg_pair_t pair_queue [$];
	logic [DIST_WIDTH-1:0] distance_queue [$];
	logic [THRESH_WIDTH-1:0] point_threshold = THRESH_RESET;
	int errors = 0;
	bit no_idle = 1'b0;
	seg_pair_t held_pair;
	int send_gap = 0;
	int recv_stall = 0;

	task automatic report(input string msg);
		$display("mismatch: %s", msg);
		errors++;
	endtask

	// Clamped ratio num/den in [0,1] with PARAM_BITS fraction bits.
	function automatic wide_t clamp_ratio(input wide_t num, input wide_t den);
		if (den <= 0 || num <= 0)
			return 0;
		if (num >= den)
			return wide_t'(1) <<< PARAM_BITS;
		return (num <<< PARAM_BITS) / den;
	endfunction

	function automatic logic [127:0] floor_sqrt(input logic [127:0] x);
		logic [127:0] root;
		logic [127:0] bitv;
		root = 0;
		bitv = 128'b1 << 126;
		while (bitv > x)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (x >= root + bitv) begin
				x = x - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		return root;
	endfunction

	// Closest-point distance of one pair under the current threshold.
	function automatic logic [DIST_WIDTH-1:0] pair_distance(input seg_pair_t p);
		wide_t d1 [3];
		wide_t d2 [3];
		wide_t r [3];
		wide_t a, e, f, b, c, denom, num, den, s, t, comp, sq;
		logic [127:0] root;
		bit first_point, second_point;
		for (int k = 0; k < 3; k++) begin
			d1[k] = wide_t'(p.c[3+k]) - wide_t'(p.c[k]);
			d2[k] = wide_t'(p.c[9+k]) - wide_t'(p.c[6+k]);
			r[k]  = wide_t'(p.c[k]) - wide_t'(p.c[6+k]);
		end
		a = d1[0]*d1[0] + d1[1]*d1[1] + d1[2]*d1[2];
		e = d2[0]*d2[0] + d2[1]*d2[1] + d2[2]*d2[2];
		f = d2[0]*r[0] + d2[1]*r[1] + d2[2]*r[2];
		c = d1[0]*r[0] + d1[1]*r[1] + d1[2]*r[2];
		b = d1[0]*d2[0] + d1[1]*d2[1] + d1[2]*d2[2];
		first_point = a <= wide_t'(point_threshold);
		second_point = e <= wide_t'(point_threshold);
		s = 0;
		t = 0;
		if (first_point && second_point) begin
			// Both segments collapse to their start points.
		end else if (first_point) begin
			t = clamp_ratio(f, e);
		end else if (second_point) begin
			s = clamp_ratio(-c, a);
		end else begin
			denom = a*e - b*b;
			s = clamp_ratio(b*f - c*e, denom);
			num = b*s + (f <<< PARAM_BITS);
			den = e <<< PARAM_BITS;
			if (num < 0) begin
				t = 0;
				s = clamp_ratio(-c, a);
			end else if (num > den) begin
				t = wide_t'(1) <<< PARAM_BITS;
				s = clamp_ratio(b - c, a);
			end else begin
				t = clamp_ratio(num, den);
			end
		end
		sq = 0;
		for (int k = 0; k < 3; k++) begin
			comp = (r[k] <<< PARAM_BITS) + d1[k]*s - d2[k]*t;
			sq = sq + comp*comp;
		end
		root = floor_sqrt(sq) >> PARAM_BITS;
		if (root > 128'(DIST_MAX))
			return DIST_MAX;
		return root[DIST_WIDTH-1:0];
	endfunction

	function automatic seg_pair_t make_pair(input int v [12]);
		seg_pair_t p;
		for (int k = 0; k < 12; k++)
			p.c[k] = CW'(v[k]);
		return p;
	endfunction

	function automatic int offset(input int bits);
		return int'($urandom_range(0, 2 ** (bits + 1))) - 2 ** bits;
	endfunction

	// Random pair; four in ten are nearby segments so that every clamping branch is reached,
	// the rest are full-range noise, collapsed segments and parallel segments.
	function automatic seg_pair_t random_pair();
		int v [12];
		int mode, span, base;
		mode = $urandom_range(0, 9);
		span = $urandom_range(2, 17);
		for (int k = 0; k < 3; k++) begin
			base = offset(22);
			v[k] = base + offset(span);
			v[3+k] = v[k] + offset(span);
			v[6+k] = base + offset(span);
			v[9+k] = v[6+k] + offset(span);
		end
		case (mode)
			0, 1: begin
				for (int k = 0; k < 12; k++)
					v[k] = int'($urandom);
			end
			6: begin
				for (int k = 0; k < 3; k++)
					v[3+k] = v[k] + offset($urandom_range(0, 6));
			end
			7: begin
				for (int k = 0; k < 3; k++)
					v[9+k] = v[6+k] + offset($urandom_range(0, 6));
			end
			8: begin
				for (int k = 0; k < 3; k++) begin
					v[3+k] = v[k] + offset($urandom_range(0, 5));
					v[9+k] = v[6+k] + offset($urandom_range(0, 5));
				end
			end
			9: begin
				// Second direction is the first one, or its double, so b*b equals a*e.
				base = $urandom_range(1, 2);
				for (int k = 0; k < 3; k++)
					v[9+k] = v[6+k] + base * (v[3+k] - v[k]);
			end
			default: ;
		endcase
		return make_pair(v);
	endfunction

	// Input side: one transaction is offered at a time from the pending queue.
	always @(posedge clk) begin
		if (!arst_n) begin
			seg_if.valid <= 1'b0;
		end else begin
			if (seg_if.valid && seg_if.ready) begin
				distance_queue.push_back(pair_distance(held_pair));
				if (!no_idle && $urandom_range(0, 5) == 0)
					send_gap = $urandom_range(1, 18);
			end
			if (seg_if.valid && !seg_if.ready) begin
				// Hold the offered transaction until it is taken.
			end else if (send_gap > 0) begin
				send_gap--;
				seg_if.valid <= 1'b0;
			end else if (pair_queue.size() > 0) begin
				held_pair = pair_queue.pop_front();
				seg_if.valid <= 1'b1;
				seg_if.first_start_x  <= held_pair.c[0];
				seg_if.first_start_y  <= held_pair.c[1];
				seg_if.first_start_z  <= held_pair.c[2];
				seg_if.first_end_x    <= held_pair.c[3];
				seg_if.first_end_y    <= held_pair.c[4];
				seg_if.first_end_z    <= held_pair.c[5];
				seg_if.second_start_x <= held_pair.c[6];
				seg_if.second_start_y <= held_pair.c[7];
				seg_if.second_start_z <= held_pair.c[8];
				seg_if.second_end_x   <= held_pair.c[9];
				seg_if.second_end_y   <= held_pair.c[10];
				seg_if.second_end_z   <= held_pair.c[11];
			end else begin
				seg_if.valid <= 1'b0;
			end
		end
	end

	// Output side: random stall bursts, then each transaction is checked in order.
	always @(posedge clk) begin
		if (!arst_n) begin
			dist_if.ready <= 1'b0;
		end else begin
			if (dist_if.valid && dist_if.ready) begin
				if (distance_queue.size() == 0)
					report($sformatf("unexpected distance %0d", dist_if.distance));
				else begin
					if (dist_if.distance !== distance_queue[0])
						report($sformatf("distance %0d, predicted %0d",
							dist_if.distance, distance_queue[0]));
					void'(distance_queue.pop_front());
				end
			end
			if (recv_stall > 0) begin
				recv_stall--;
				dist_if.ready <= 1'b0;
			end else begin
				dist_if.ready <= 1'b1;
				if (!no_idle && $urandom_range(0, 7) == 0)
					recv_stall = $urandom_range(1, 18);
			end
		end
	end

	task automatic wait_idle();
		while (pair_queue.size() > 0 || seg_if.valid || distance_queue.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// The threshold register is written only once the pipeline has drained.
	task automatic write_threshold(input logic [THRESH_WIDTH-1:0] value);
		wait_idle();
		cfg_if.valid <= 1'b1;
		cfg_if.data <= value;
		do @(posedge clk); while (!cfg_if.ready);
		point_threshold = value;
		cfg_if.valid <= 1'b0;
	endtask

	task automatic queue_random(input int count);
		repeat (count) pair_queue.push_back(random_pair());
	endtask

	initial begin
		int mx, mn, u;
		seg_if.valid = 1'b0;
		for (int k = 0; k < 12; k++) ;
		{seg_if.first_start_x, seg_if.first_start_y, seg_if.first_start_z} = '0;
		{seg_if.first_end_x, seg_if.first_end_y, seg_if.first_end_z} = '0;
		{seg_if.second_start_x, seg_if.second_start_y, seg_if.second_start_z} = '0;
		{seg_if.second_end_x, seg_if.second_end_y, seg_if.second_end_z} = '0;
		dist_if.ready = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.data = '0;
		mx = 8388607;
		mn = -8388608;
		u = 4096;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed pairs at the reset threshold: extremes of the coordinates and
		// each clamping branch.
		pair_queue.push_back(make_pair('{0,0,0, 0,0,0, 0,0,0, 0,0,0}));
		pair_queue.push_back(make_pair('{mx,mx,mx, mx,mx,mx, mx,mx,mx, mx,mx,mx}));
		pair_queue.push_back(make_pair('{mn,mn,mn, mn,mn,mn, mn,mn,mn, mn,mn,mn}));
		pair_queue.push_back(make_pair('{mx,mx,mx, mx,mx,mx, mn,mn,mn, mn,mn,mn}));
		pair_queue.push_back(make_pair('{mx,mx,mx, mn,mn,mn, mn,mx,mn, mx,mn,mx}));
		pair_queue.push_back(make_pair('{mn,mx,mn, mx,mn,mx, mn,mn,mn, mx,mx,mx}));
		pair_queue.push_back(make_pair('{mx,mn,mx, mx,mn,mx, mn,mx,mn, mn,mx,mn}));
		// Both points, first point, second point.
		pair_queue.push_back(make_pair('{u,u,u, u+20,u,u, -u,0,u, -u,30,u}));
		pair_queue.push_back(make_pair('{u,u,u, u,u+5,u, 0,0,0, 100*u,0,0}));
		pair_queue.push_back(make_pair('{0,0,0, 100*u,0,0, 50*u,7*u,0, 50*u,7*u,9}));
		// Parallel segments, collinear and offset.
		pair_queue.push_back(make_pair('{0,0,0, 10*u,0,0, 5*u,u,0, 25*u,u,0}));
		pair_queue.push_back(make_pair('{0,0,0, 10*u,0,0, 20*u,0,0, 30*u,0,0}));
		// t below 0, t above 1, t inside.
		pair_queue.push_back(make_pair('{0,0,0, 100*u,0,0, 50*u,10*u,0, 50*u,20*u,0}));
		pair_queue.push_back(make_pair('{0,0,0, 100*u,0,0, 50*u,-20*u,0, 50*u,-10*u,0}));
		pair_queue.push_back(make_pair('{0,0,0, 100*u,0,0, 50*u,-10*u,5*u, 50*u,10*u,5*u}));
		// s clamped at both ends.
		pair_queue.push_back(make_pair('{0,0,0, 10*u,0,0, -5*u,-u,u, -5*u,u,u}));
		pair_queue.push_back(make_pair('{0,0,0, 10*u,0,0, 15*u,-u,u, 15*u,u,u}));
		// Squared length just below and just above the reset threshold (40*40 < 1678 < 41*41).
		pair_queue.push_back(make_pair('{0,0,0, 40,0,0, u,u,u, u,u,u+41}));
		pair_queue.push_back(make_pair('{0,0,0, 41,0,0, u,u,u, u,u,u+40}));
		queue_random(ITEMS_PER_PHASE);

		write_threshold('0);
		pair_queue.push_back(make_pair('{0,0,0, 1,0,0, u,u,u, u,u,u+1}));
		queue_random(ITEMS_PER_PHASE);

		write_threshold(THRESH_WIDTH'(16777216));
		pair_queue.push_back(make_pair('{0,0,0, 4096,0,0, u,u,u, u,u,u+4097}));
		queue_random(ITEMS_PER_PHASE);

		write_threshold(THRESH_WIDTH'($urandom_range(0, 16777216)));
		queue_random(ITEMS_PER_PHASE);

		// Last phase runs at full rate on both sides.
		write_threshold(THRESH_RESET);
		no_idle = 1'b1;
		queue_random(ITEMS_PER_PHASE);

		wait_idle();
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#2000000;
		$display("FAIL");
		$finish;
	end

endmodule

@@ segment_segment_distance.f @@
rtl/ssd_pkg.sv
rtl/ssd_ifs.sv
rtl/ssd_delay.sv
rtl/ssd_mul.sv
rtl/ssd_div.sv
rtl/ssd_sqrt.sv
rtl/segment_segment_distance.sv
dv/testbench.sv
